/* src/presence_gated_motor_cycle_sequencer_defines.svh */
// ---------------------------------------------------------------------------
// Presence-gated motor cycle sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef PRESENCE_GATED_MOTOR_CYCLE_SEQUENCER_DEFINES_SVH
`define PRESENCE_GATED_MOTOR_CYCLE_SEQUENCER_DEFINES_SVH

// Checked only outside reset
`define PGMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define PGMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pgms_pkg.sv */
// ---------------------------------------------------------------------------
// pgms_pkg
// Types and constants shared by the motor cycle sequencer modules.
// ---------------------------------------------------------------------------
package pgms_pkg;

    localparam int DUTY_W     = 8;
    localparam int TIMER_W    = 16;
    localparam int MODE_AGE_W = 16;
    localparam int EDGE_AGE_W = 10;
    localparam int COOL_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Operating modes, as reported on the result word
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PRESENT = 3'd1,
        MODE_WAIT    = 3'd2,
        MODE_RUN     = 3'd3,
        MODE_COOL    = 3'd4,
        MODE_STOP    = 3'd5
    } mode_t;

    // Phases of a motor run
    typedef enum logic [2:0] {
        PH_NONE  = 3'd0,
        PH_UP    = 3'd1,
        PH_HOLD  = 3'd2,
        PH_DOWN  = 3'd3,
        PH_PAUSE = 3'd4
    } phase_t;

    // Commands carried with each tick
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_STOP  = 2'd1,
        OP_RESET = 2'd2,
        OP_RUN   = 2'd3
    } op_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ACTIVE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_ON_ARRIVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_PEAK          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INCREMENT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS      = 3'd7;

    typedef struct packed {
        logic                  sensor_active_low;
        logic                  trigger_on_arrival;
        logic [DUTY_W-1:0]     duty_peak;
        logic [7:0]            ramp_increment;
        logic [7:0]            ramp_step_ticks;
        logic [TIMER_W-1:0]    hold_ticks;
        logic [COOL_W-1:0]     cooldown_ticks;
        logic [TIMER_W-1:0]    confirm_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sensor_active_low:  1'b1,
        trigger_on_arrival: 1'b0,
        duty_peak:          8'd220,
        ramp_increment:     8'd5,
        ramp_step_ticks:    8'd8,
        hold_ticks:         16'd3500,
        cooldown_ticks:     18'd180000,
        confirm_ticks:      16'd1500
    };

    typedef struct packed {
        logic              presence;
        logic              edge_pulse;
        mode_t             mode;
        logic              indicator;
        logic [DUTY_W-1:0] motor_duty;
    } result_t;

endpackage

/* src/presence_gated_motor_cycle_sequencer.sv */
// ---------------------------------------------------------------------------
// presence_gated_motor_cycle_sequencer
// Presence-gated motor run sequencer, one word in and one word out per tick.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one word per millisecond tick: sensor level and a command.
//   m_* returns one word per tick: duty, lamp, mode, edge pulse, presence.
//   cfg_* writes the eight settings registers; it is always ready and should
//   be used only while no tick is in flight.
// Timing:
//   A tick word is held in the input register, then its result is loaded
//   into the output register, which drives m_tvalid. One word per cycle
//   is sustained while m_tready is high; the combinational mode and ramp
//   update between the two registers sets that rate.
// Stalls:
//   With m_tready low the result holds, an empty input register still takes
//   one more word, and then s_tready drops until the output drains.
// Reset:
//   rst_n clears both registers' valid flags, the mode state (idle, no run,
//   all ages zero) and restores the default settings.
// ---------------------------------------------------------------------------
`include "presence_gated_motor_cycle_sequencer_defines.svh"

module presence_gated_motor_cycle_sequencer #(
    parameter int DEBOUNCE_TICKS = 80,
    parameter int PAUSE_TICKS    = 800,
    parameter int ELAPSED_BITS   = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] sensor_level, [2:1] operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [7:0] motor_duty, [8] indicator,
                                                        // [11:9] mode, [12] edge_pulse,
                                                        // [13] presence
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pgms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pgms_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    m_valid_reg;
    logic    in_valid_reg;
    logic    sensor_reg;
    op_t     op_reg;
    logic    advance;
    logic    s_take;

    pgms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake control
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    pgms_seq #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
        .PAUSE_TICKS    (PAUSE_TICKS),
        .ELAPSED_BITS   (ELAPSED_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .sensor_level (sensor_reg),
        .operation    (op_reg),
        .cfg          (cfg),
        .res          (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            sensor_reg <= s_tdata[0];
            op_reg     <= op_t'(s_tdata[2:1]);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg.presence, out_reg.edge_pulse, out_reg.mode,
                       out_reg.indicator, out_reg.motor_duty};

    // a pending tick moves on as soon as the output is free
    `PGMS_ASSERT(a_no_bubble, in_valid_reg && !m_valid_reg |=> m_valid_reg, "tick not forwarded")
    // the edge tracker reports no edge while stopped
    `PGMS_ASSERT(a_edge_not_stop, m_valid_reg && out_reg.edge_pulse |-> out_reg.mode != MODE_STOP, "edge in stop mode")
    // no word left pending after reset
    `PGMS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !m_valid_reg && !in_valid_reg, "valid after reset")

endmodule

/* src/pgms_cfg.sv */
// ---------------------------------------------------------------------------
// pgms_cfg
// Configuration register file, written through the cfg channel.
// ---------------------------------------------------------------------------
module pgms_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pgms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pgms_pkg::cfg_t                   cfg
);
    import pgms_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SENSOR_ACTIVE_LOW:  cfg_reg.sensor_active_low  <= cfg_data[0];
                REG_TRIGGER_ON_ARRIVAL: cfg_reg.trigger_on_arrival <= cfg_data[0];
                REG_DUTY_PEAK:          cfg_reg.duty_peak          <= cfg_data[DUTY_W-1:0];
                REG_RAMP_INCREMENT:     cfg_reg.ramp_increment     <= cfg_data[7:0];
                REG_RAMP_STEP_TICKS:    cfg_reg.ramp_step_ticks    <= cfg_data[7:0];
                REG_HOLD_TICKS:         cfg_reg.hold_ticks         <= cfg_data[TIMER_W-1:0];
                REG_COOLDOWN_TICKS:     cfg_reg.cooldown_ticks     <= cfg_data[COOL_W-1:0];
                REG_CONFIRM_TICKS:      cfg_reg.confirm_ticks      <= cfg_data[TIMER_W-1:0];
                default:                ;
            endcase
        end
    end

endmodule

/* src/pgms_seq.sv */
// ---------------------------------------------------------------------------
// pgms_seq
// Per-tick mode machine, edge tracker and run ramp, with its state registers.
// ---------------------------------------------------------------------------
`include "presence_gated_motor_cycle_sequencer_defines.svh"

module pgms_seq #(
    parameter int DEBOUNCE_TICKS = 80,
    parameter int PAUSE_TICKS    = 800,
    parameter int ELAPSED_BITS   = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic                sensor_level,
    input  pgms_pkg::op_t       operation,
    input  pgms_pkg::cfg_t      cfg,
    output pgms_pkg::result_t   res
);
    import pgms_pkg::*;

    localparam int CMP_W = (ELAPSED_BITS > COOL_W) ? ELAPSED_BITS : COOL_W;
    localparam logic [EDGE_AGE_W-1:0] DEB_T   = EDGE_AGE_W'(DEBOUNCE_TICKS);
    localparam logic [TIMER_W-1:0]    PAUSE_T = TIMER_W'(PAUSE_TICKS);
    localparam bit                    PAUSE_ZERO = (PAUSE_TICKS == 0);

    mode_t                   mode_reg,   mode_next;
    phase_t                  phase_reg,  phase_next;
    logic [TIMER_W-1:0]      timer_reg,  timer_next;
    logic [DUTY_W-1:0]       ramp_reg,   ramp_next;
    logic [MODE_AGE_W-1:0]   age_reg,    age_next;
    logic [ELAPSED_BITS-1:0] srun_reg,   srun_next;
    logic                    ever_reg,   ever_next;
    logic [EDGE_AGE_W-1:0]   sedge_reg,  sedge_next;
    logic                    prior_reg,  prior_next;

    logic                    pres;
    logic                    edge_hit;
    logic                    cool_active;
    logic                    do_tick;
    logic [7:0]              step_len;
    logic [7:0]              incr;
    logic [ELAPSED_BITS-1:0] srun_inc;
    logic [DUTY_W-1:0]       duty;
    logic [DUTY_W:0]         ramp_sum;
    phase_t                  rt_phase;
    logic [TIMER_W-1:0]      rt_timer;
    logic [DUTY_W-1:0]       rt_ramp;
    mode_t                   m;

    // Tick update
    always_comb
    begin
        pres     = cfg.sensor_active_low ? ~sensor_level : sensor_level;
        step_len = (cfg.ramp_step_ticks == 8'd0) ? 8'd1 : cfg.ramp_step_ticks;
        incr     = (cfg.ramp_increment == 8'd0) ? 8'd1 : cfg.ramp_increment;

        // ages advance first, saturating
        age_next   = (age_reg != '1) ? age_reg + 1'b1 : age_reg;
        srun_inc   = (srun_reg != '1) ? srun_reg + 1'b1 : srun_reg;
        srun_next  = srun_inc;
        sedge_next = (sedge_reg != '1) ? sedge_reg + 1'b1 : sedge_reg;

        cool_active = ever_reg && (CMP_W'(srun_inc) < CMP_W'(cfg.cooldown_ticks));

        m          = mode_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        ramp_next  = ramp_reg;
        ever_next  = ever_reg;
        prior_next = prior_reg;
        edge_hit   = 1'b0;
        do_tick    = 1'b0;
        duty       = '0;
        ramp_sum   = '0;
        rt_phase   = phase_reg;
        rt_timer   = timer_reg;
        rt_ramp    = ramp_reg;

        if (mode_reg == MODE_RUN && phase_reg != PH_NONE)
        begin
            do_tick = 1'b1;
        end
        else
        begin
            // command
            case (operation)
                OP_STOP:
                begin
                    m = MODE_STOP;
                    age_next = '0;
                end
                OP_RESET:
                begin
                    m = MODE_IDLE;
                    age_next = '0;
                end
                OP_RUN:
                begin
                    if (m != MODE_STOP)
                    begin
                        m = MODE_RUN;
                        age_next = '0;
                    end
                end
                default: ;
            endcase

            if (m != MODE_STOP)
            begin
                if (pres && m == MODE_IDLE)
                begin
                    m = MODE_PRESENT;
                    age_next = '0;
                end

                // debounced edge, held off after the last one
                if (sedge_next >= DEB_T)
                begin
                    edge_hit = cfg.trigger_on_arrival ? (pres && !prior_reg)
                                                      : (!pres && prior_reg);
                    if (edge_hit)
                    begin
                        sedge_next = '0;
                    end
                end
                prior_next = pres;

                case (m)
                    MODE_PRESENT:
                    begin
                        if (!cfg.trigger_on_arrival && edge_hit)
                        begin
                            m = MODE_WAIT;
                            age_next = '0;
                        end
                    end
                    MODE_WAIT:
                    begin
                        if (pres)
                        begin
                            m = MODE_PRESENT;
                            age_next = '0;
                        end
                        else if (cool_active)
                        begin
                            m = MODE_COOL;
                            age_next = '0;
                        end
                        else if (age_next >= cfg.confirm_ticks)
                        begin
                            m = MODE_RUN;
                            age_next = '0;
                        end
                    end
                    MODE_RUN:
                    begin
                        if (pres)
                        begin
                            m = MODE_PRESENT;
                            age_next = '0;
                        end
                        else
                        begin
                            // start of ramp up, first tick runs now
                            do_tick  = 1'b1;
                            rt_phase = PH_UP;
                            rt_timer = TIMER_W'(step_len);
                            rt_ramp  = '0;
                        end
                    end
                    MODE_COOL:
                    begin
                        if (ever_reg && CMP_W'(srun_inc) >= CMP_W'(cfg.cooldown_ticks))
                        begin
                            m = MODE_IDLE;
                            age_next = '0;
                        end
                    end
                    MODE_IDLE: ;
                    default:
                    begin
                        m = MODE_IDLE;
                        age_next = '0;
                    end
                endcase
            end
        end

        mode_next = m;

        // one ramp tick
        if (do_tick)
        begin
            if (rt_phase == PH_UP || rt_phase == PH_DOWN)
                duty = rt_ramp;
            else if (rt_phase == PH_HOLD)
                duty = cfg.duty_peak;

            phase_next = rt_phase;
            ramp_next  = rt_ramp;

            if (rt_timer > TIMER_W'(1))
            begin
                timer_next = rt_timer - 1'b1;
            end
            else
            begin
                timer_next = '0;
                case (rt_phase)
                    PH_UP:
                    begin
                        ramp_sum = {1'b0, rt_ramp} + {1'b0, incr};
                        if (ramp_sum <= {1'b0, cfg.duty_peak})
                        begin
                            ramp_next  = ramp_sum[DUTY_W-1:0];
                            timer_next = TIMER_W'(step_len);
                        end
                        else if (cfg.hold_ticks == '0)
                        begin
                            phase_next = PH_DOWN;
                            ramp_next  = cfg.duty_peak;
                            timer_next = TIMER_W'(step_len);
                        end
                        else
                        begin
                            phase_next = PH_HOLD;
                            timer_next = cfg.hold_ticks;
                        end
                    end
                    PH_HOLD:
                    begin
                        phase_next = PH_DOWN;
                        ramp_next  = cfg.duty_peak;
                        timer_next = TIMER_W'(step_len);
                    end
                    PH_DOWN:
                    begin
                        if (rt_ramp >= incr)
                        begin
                            ramp_next  = rt_ramp - incr;
                            timer_next = TIMER_W'(step_len);
                        end
                        else if (!PAUSE_ZERO)
                        begin
                            phase_next = PH_PAUSE;
                            timer_next = PAUSE_T;
                        end
                        else
                        begin
                            phase_next = PH_NONE;
                            mode_next  = MODE_COOL;
                            age_next   = '0;
                            srun_next  = '0;
                            ever_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        // end of run
                        phase_next = PH_NONE;
                        mode_next  = MODE_COOL;
                        age_next   = '0;
                        srun_next  = '0;
                        ever_next  = 1'b1;
                    end
                endcase
            end
        end

        res.motor_duty = duty;
        res.indicator  = (mode_next == MODE_PRESENT) || (mode_next == MODE_WAIT) ||
                         (mode_next == MODE_RUN);
        res.mode       = mode_next;
        res.edge_pulse = edge_hit;
        res.presence   = pres;
    end

    // State registers, updated once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= PH_NONE;
            timer_reg <= '0;
            ramp_reg  <= '0;
            age_reg   <= '0;
            srun_reg  <= '0;
            ever_reg  <= 1'b0;
            sedge_reg <= '0;
            prior_reg <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            ramp_reg  <= ramp_next;
            age_reg   <= age_next;
            srun_reg  <= srun_next;
            ever_reg  <= ever_next;
            sedge_reg <= sedge_next;
            prior_reg <= prior_next;
        end
    end

    // a run phase only exists in run mode
    `PGMS_ASSERT(a_phase_in_run, phase_reg != PH_NONE |-> mode_reg == MODE_RUN, "run phase outside run mode")
    // state moves only on a tick
    `PGMS_ASSERT(a_state_on_step, !step_en |=> $stable(mode_reg) && $stable(phase_reg), "state changed without tick")

endmodule
